@@ hdl/utf8_stream_decoder_assert.svh @@
// assertion macros for the port-level checker
`ifndef UTF8_STREAM_DECODER_ASSERT_SVH
`define UTF8_STREAM_DECODER_ASSERT_SVH

// expression must hold at every clock edge outside reset
`define USD_ASSERT_ALWAYS(label, expr, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (expr)) \
      else $error(msg);

// consequent must hold in the cycle after the antecedent
`define USD_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ hdl/usd_pkg.sv @@
// shared types, constants and decode functions for the utf-8 stream decoder
package usd_pkg;

   localparam int WIN_DEPTH = 4;
   localparam int CP_WIDTH  = 21;

   localparam logic [CP_WIDTH-1:0] REPL_CHAR = 21'h00FFFD;

   localparam logic [7:0] ASCII_LIMIT = 8'h80;
   localparam logic [7:0] LEAD2_MASK  = 8'hE0;
   localparam logic [7:0] LEAD2_TAG   = 8'hC0;
   localparam logic [7:0] LEAD3_MASK  = 8'hF0;
   localparam logic [7:0] LEAD3_TAG   = 8'hE0;
   localparam logic [7:0] LEAD4_MASK  = 8'hF8;
   localparam logic [7:0] LEAD4_TAG   = 8'hF0;
   localparam logic [7:0] CONT_MASK   = 8'hC0;
   localparam logic [7:0] CONT_TAG    = 8'h80;

   // sequence length codes; zero marks a byte that cannot start a sequence
   localparam logic [2:0] LEN_BAD = 3'd0;
   localparam logic [2:0] LEN_ONE = 3'd1;
   localparam logic [2:0] LEN_TWO = 3'd2;
   localparam logic [2:0] LEN_THR = 3'd3;
   localparam logic [2:0] LEN_FOR = 3'd4;

   typedef logic [WIN_DEPTH-1:0][7:0] win_type;

   typedef struct packed {
      logic [7:0] in_byte;
      logic       end_of_data;
   } req_type;

   typedef struct packed {
      logic [CP_WIDTH-1:0] code_point;
      logic                replaced;
      logic                run_last;
      logic                stream_end;
   } rsp_type;

   typedef struct packed {
      logic                emit;
      logic                repl;
      logic [2:0]          consume;
      logic [CP_WIDTH-1:0] cp;
   } step_type;

   typedef struct packed {
      logic load;
      logic advance;
   } ctrl_cmd_type;

   typedef struct packed {
      logic emit;
      logic last;
      logic out_free;
   } dp_status_type;

   function automatic logic [2:0] lead_len(input logic [7:0] c);
      logic [2:0] len;
      if (c < ASCII_LIMIT) begin
         len = LEN_ONE;
      end else if ((c & LEAD2_MASK) == LEAD2_TAG) begin
         len = LEN_TWO;
      end else if ((c & LEAD3_MASK) == LEAD3_TAG) begin
         len = LEN_THR;
      end else if ((c & LEAD4_MASK) == LEAD4_TAG) begin
         len = LEN_FOR;
      end else begin
         len = LEN_BAD;
      end
      return len;
   endfunction

   function automatic logic is_cont(input logic [7:0] c);
      return (c & CONT_MASK) == CONT_TAG;
   endfunction

   // decoding of the window front gives nothing more for this byte
   function automatic logic is_stop(input logic [7:0] c, input logic [2:0] cnt,
                                    input logic eod);
      logic [2:0] len;
      logic       stop;
      len = lead_len(c);
      if (cnt == 3'd0) begin
         stop = 1'b1;
      end else begin
         stop = !eod && (len > LEN_ONE) && (cnt < len);
      end
      return stop;
   endfunction

   function automatic step_type decode_step(input win_type w, input logic [2:0] cnt,
                                            input logic eod);
      step_type   s;
      logic [2:0] len;
      logic       cont_ok;
      s.emit    = 1'b0;
      s.repl    = 1'b0;
      s.consume = 3'd0;
      s.cp      = REPL_CHAR;
      len       = lead_len(w[0]);
      cont_ok   = is_cont(w[1]) && ((len < LEN_THR) || is_cont(w[2]))
                  && ((len < LEN_FOR) || is_cont(w[3]));
      if (cnt == 3'd0) begin
         s.emit = 1'b0;
      end else if (len == LEN_ONE) begin
         s.emit    = 1'b1;
         s.consume = 3'd1;
         s.cp      = {13'd0, w[0]};
      end else if (len == LEN_BAD) begin
         s.emit    = 1'b1;
         s.repl    = 1'b1;
         s.consume = 3'd1;
      end else if (cnt < len) begin
         // cut off: wait for more bytes, or give up at end of data
         s.emit    = eod;
         s.repl    = eod;
         s.consume = eod ? 3'd1 : 3'd0;
      end else if (!cont_ok) begin
         s.emit    = 1'b1;
         s.repl    = 1'b1;
         s.consume = 3'd1;
      end else begin
         s.emit    = 1'b1;
         s.consume = len;
         case (len)
            LEN_TWO: s.cp = {10'd0, w[0][4:0], w[1][5:0]};
            LEN_THR: s.cp = {5'd0, w[0][3:0], w[1][5:0], w[2][5:0]};
            LEN_FOR: s.cp = {w[0][2:0], w[1][5:0], w[2][5:0], w[3][5:0]};
            default: s.cp = REPL_CHAR;
         endcase
      end
      return s;
   endfunction

endpackage

@@ hdl/usd_ctrl.sv @@
// controller: takes a byte, then steps the decoder until the window stops
module usd_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  usd_pkg::dp_status_type status,
   output usd_pkg::ctrl_cmd_type  cmd
);
   import usd_pkg::*;

   localparam logic ST_IDLE = 1'b0;
   localparam logic ST_RUN  = 1'b1;

   logic state_ff;
   logic state_in;

   always_comb begin
      cmd.load    = (state_ff == ST_IDLE) && req_valid;
      cmd.advance = (state_ff == ST_RUN) && status.emit && status.out_free;
      state_in    = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (cmd.load) begin
               state_in = ST_RUN;
            end
         end
         ST_RUN: begin
            // nothing to release, or the final result of this beat goes out
            if (!status.emit || (cmd.advance && status.last)) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign req_stall = (state_ff != ST_IDLE);

endmodule

@@ hdl/usd_datapath.sv @@
// datapath: byte window, one-step decoder and result register
module usd_datapath (
   input  logic                   clock,
   input  logic                   reset,
   input  usd_pkg::req_type       req_data,
   input  usd_pkg::ctrl_cmd_type  cmd,
   output usd_pkg::dp_status_type status,
   input  logic                   rsp_stall,
   output logic                   rsp_valid,
   output usd_pkg::rsp_type       rsp_data
);
   import usd_pkg::*;

   win_type    win_ff;
   win_type    win_in;
   logic [2:0] cnt_ff;
   logic [2:0] cnt_in;
   logic       eod_ff;
   logic       eod_in;
   logic       rsp_valid_ff;
   logic       rsp_valid_in;
   rsp_type    rsp_data_ff;
   rsp_type    rsp_data_in;

   step_type   step;
   logic [2:0] cnt_left;
   logic       last;
   logic [2:0] src_idx;

   always_comb begin
      step     = decode_step(win_ff, cnt_ff, eod_ff);
      cnt_left = cnt_ff - step.consume;
      // look at the window after this result to see whether it is the final one
      last     = is_stop(win_ff[step.consume[1:0]], cnt_left, eod_ff);
   end

   always_comb begin
      win_in  = win_ff;
      cnt_in  = cnt_ff;
      eod_in  = eod_ff;
      src_idx = 3'd0;
      if (cmd.load) begin
         win_in[cnt_ff[1:0]] = req_data.in_byte;
         cnt_in              = cnt_ff + 3'd1;
         eod_in              = req_data.end_of_data;
      end else if (cmd.advance) begin
         cnt_in = cnt_left;
         for (int i = 0; i < WIN_DEPTH; i++) begin
            src_idx = 3'(i) + step.consume;
            if (src_idx < 3'(WIN_DEPTH)) begin
               win_in[i] = win_ff[src_idx[1:0]];
            end
         end
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (cmd.advance) begin
         rsp_valid_in           = 1'b1;
         rsp_data_in.code_point = step.cp;
         rsp_data_in.replaced   = step.repl;
         rsp_data_in.run_last   = last;
         rsp_data_in.stream_end = last && eod_ff;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff       <= 3'd0;
         rsp_valid_ff <= 1'b0;
      end else begin
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      win_ff      <= win_in;
      eod_ff      <= eod_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign status.emit     = step.emit;
   assign status.last     = last;
   assign status.out_free = !rsp_valid_ff || !rsp_stall;

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

@@ hdl/utf8_stream_decoder.sv @@
// utf-8 stream decoder top level: byte beats in, code point beats out
//
//   channel  dir  handshake             beat contents
//   req      in   req_valid/req_stall   in_byte, end_of_data
//   rsp      out  rsp_valid/rsp_stall   code_point, replaced, run_last, stream_end
//
// a byte beat is loaded first, then the decode step releases its results one
// by one until the window stops: one for a plain ascii byte and up to four
// when an error rescan fires. a byte that completes nothing releases none.
// reset is synchronous: held bytes are dropped and the rsp register empties.
// rsp_stall holds the decode step; the next byte is taken while a result waits.
module utf8_stream_decoder (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  usd_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output usd_pkg::rsp_type rsp_data
);
   import usd_pkg::*;

   ctrl_cmd_type  cmd;
   dp_status_type status;

   usd_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .status    (status),
      .cmd       (cmd)
   );

   usd_datapath u_datapath (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .cmd       (cmd),
      .status    (status),
      .rsp_stall (rsp_stall),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

endmodule

@@ hdl/usd_checker.sv @@
// port-level checker for the utf-8 stream decoder, bound to the top level
`include "utf8_stream_decoder_assert.svh"

module usd_checker (
   input logic             clock,
   input logic             reset,
   input logic             req_valid,
   input logic             req_stall,
   input usd_pkg::req_type req_data,
   input logic             rsp_valid,
   input logic             rsp_stall,
   input usd_pkg::rsp_type rsp_data
);
   import usd_pkg::*;

   `USD_ASSERT_NEXT(a_rsp_hold, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_data), "rsp beat changed while stalled")

   `USD_ASSERT_ALWAYS(a_end_is_last, !rsp_valid || !rsp_data.stream_end || rsp_data.run_last, "stream_end without run_last")

   `USD_ASSERT_ALWAYS(a_repl_value, !rsp_valid || !rsp_data.replaced || (rsp_data.code_point == REPL_CHAR), "replaced beat without replacement value")

   `USD_ASSERT_NEXT(a_busy_after_byte, req_valid && !req_stall, req_stall, "byte taken while previous byte still decoding")

endmodule

bind utf8_stream_decoder usd_checker u_usd_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_stall (req_stall),
   .req_data  (req_data),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_data  (rsp_data)
);
